// File: rtl/core/pcd_pkg.sv
// ----------------------------------------------------------------------------
// pcd_pkg: shared definitions of the page coherence directory
// Sizes, message codes, the directory entry layout and the control and
// status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package pcd_pkg;

  localparam int NODES          = 8;
  localparam int DIR_INDEX_BITS = 10;
  localparam int PAGE_SHIFT     = 12;
  localparam int MAX_RESULTS    = 8;

  localparam int DIR_DEPTH  = 1 << DIR_INDEX_BITS;
  localparam int NODE_IDX_W = (NODES > 1) ? $clog2(NODES) : 1;

  // Fixed message field widths.
  localparam int MODE_W = 2;
  localparam int NODE_W = 3;
  localparam int ADDR_W = 32;
  localparam int PERM_W = 2;
  localparam int PEND_W = 4;
  localparam int KIND_W = 1;

  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 40;

  // Message codes.
  localparam logic [MODE_W-1:0] MODE_REQUEST = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CONTENT = 2'd1;
  localparam logic [MODE_W-1:0] MODE_ACK     = 2'd2;

  localparam logic [PERM_W-1:0] PERM_READ  = 2'd1;
  localparam logic [PERM_W-1:0] PERM_WRITE = 2'd2;

  localparam logic [KIND_W-1:0] KIND_REQUEST = 1'b0;
  localparam logic [KIND_W-1:0] KIND_FORWARD = 1'b1;

  typedef struct packed {
    logic [NODES-1:0]  owners;
    logic [NODE_W-1:0] requester;
    logic [PEND_W-1:0] pending;
  } dir_entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic ready;      // input channel may take a beat
    logic clr_we;     // write the reset entry at the sweep counter
    logic load;       // capture the input beat and read its entry
    logic lk_commit;  // finish a single-step lookup (entry update)
    logic lk_emit;    // the lookup result goes to the output register
    logic scan_load;  // start walking the owner set
    logic scan_emit;  // send one request to the next owner
  } pcd_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;
    logic is_scan;
    logic lk_emit;
    logic out_free;
    logic scan_last;
  } pcd_status_t;

  // Index of the lowest set bit; zero for an empty mask.
  function automatic logic [NODE_IDX_W-1:0] lowest_idx(input logic [NODES-1:0] m);
    logic [NODE_IDX_W-1:0] r;
    r = '0;
    for (int i = NODES - 1; i >= 0; i--) begin
      if (m[i]) begin
        r = NODE_IDX_W'(i);
      end
    end
    return r;
  endfunction

endpackage

// File: rtl/core/pcd_ctrl.sv
// ----------------------------------------------------------------------------
// pcd_ctrl: sequencer of the page coherence directory
// Runs the clearing sweep after reset, then steps each item through capture,
// lookup and, for write requests with owners, the walk over the owner set.
// ----------------------------------------------------------------------------
module pcd_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_tvalid_i,
  input  pcd_pkg::pcd_status_t status_i,
  output pcd_pkg::pcd_cmd_t    cmd_o
);
  import pcd_pkg::*;

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_LOOK  = 2'd2;
  localparam logic [1:0] ST_SCAN  = 2'd3;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_we = 1'b1;
        if (status_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        cmd_o.ready = 1'b1;
        if (s_tvalid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_LOOK;
        end
      end
      ST_LOOK: begin
        if (status_i.is_scan) begin
          cmd_o.scan_load = 1'b1;
          state_d         = ST_SCAN;
        end else if (!status_i.lk_emit || status_i.out_free) begin
          // A result waits here until the output register can take it.
          cmd_o.lk_commit = 1'b1;
          cmd_o.lk_emit   = status_i.lk_emit;
          state_d         = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (status_i.out_free) begin
          cmd_o.scan_emit = 1'b1;
          if (status_i.scan_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: rtl/core/pcd_datapath.sv
// ----------------------------------------------------------------------------
// pcd_datapath: directory memory, item registers and output register
// Holds the directory array, computes the entry update and the messages
// of an item, walks the owner set and drives the output channel.
// ----------------------------------------------------------------------------
module pcd_datapath (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  pcd_pkg::pcd_cmd_t                     cmd_i,
  output pcd_pkg::pcd_status_t                  status_o,
  input  logic [pcd_pkg::IN_TDATA_W-1:0]        s_tdata_i,
  input  logic [pcd_pkg::MODE_W-1:0]            s_tuser_i,
  output logic                                  m_tvalid_o,
  input  logic                                  m_tready_i,
  output logic [pcd_pkg::OUT_TDATA_W-1:0]       m_tdata_o,
  output logic [pcd_pkg::KIND_W-1:0]            m_tuser_o,
  output logic                                  m_tlast_o
);
  import pcd_pkg::*;

  dir_entry_t dir_mem [DIR_DEPTH];
  dir_entry_t rd_q;

  logic [DIR_INDEX_BITS-1:0] clr_cnt_q, clr_cnt_d;

  logic [MODE_W-1:0]         mode_q;
  logic [NODE_W-1:0]         src_q;
  logic [ADDR_W-1:0]         addr_q;
  logic [PERM_W-1:0]         perm_q;
  logic [DIR_INDEX_BITS-1:0] idx_q;

  logic [NODES-1:0]  rem_q;
  logic [PEND_W-1:0] cnt_q;

  logic              out_valid_q, out_valid_d;
  logic [KIND_W-1:0] out_kind_q;
  logic [NODE_W-1:0] out_dest_q;
  logic [ADDR_W-1:0] out_addr_q;
  logic [PERM_W-1:0] out_perm_q;
  logic              out_last_q;

  // Input beat unpacking.
  logic [NODE_W-1:0]         in_src;
  logic [ADDR_W-1:0]         in_addr;
  logic [PERM_W-1:0]         in_perm;
  logic [DIR_INDEX_BITS-1:0] in_idx;

  assign in_src   = s_tdata_i[NODE_W-1:0];
  assign in_addr  = s_tdata_i[NODE_W +: ADDR_W];
  assign in_perm  = s_tdata_i[NODE_W + ADDR_W +: PERM_W];
  assign in_idx   = in_addr[PAGE_SHIFT +: DIR_INDEX_BITS];

  // Lookup decisions.
  logic              perm_ok, is_rd, is_wr;
  logic              has_owner;
  logic              lk_emit, lk_write, is_scan;
  logic [NODE_W-1:0] lk_dest;
  logic [KIND_W-1:0] lk_kind;
  logic [PEND_W-1:0] pend_dec;
  dir_entry_t        lk_entry;
  logic [NODES-1:0]  ack_owners;

  assign is_rd     = (perm_q == PERM_READ);
  assign is_wr     = (perm_q == PERM_WRITE);
  assign perm_ok   = is_rd || is_wr;
  assign has_owner = |rd_q.owners;
  assign pend_dec  = rd_q.pending - PEND_W'(1);
  assign ack_owners = (is_wr ? '0 : rd_q.owners) | (NODES'(1) << src_q);

  always_comb begin
    lk_emit  = 1'b0;
    lk_write = 1'b0;
    is_scan  = 1'b0;
    lk_kind  = KIND_REQUEST;
    lk_dest  = NODE_W'(lowest_idx(rd_q.owners));
    lk_entry = rd_q;
    if (perm_ok) begin
      unique if (mode_q == MODE_REQUEST) begin
        lk_write           = 1'b1;
        lk_entry.requester = src_q;
        if (is_wr) begin
          // An empty owner set leaves nothing to wait for.
          is_scan          = has_owner;
          lk_entry.pending = '0;
        end else begin
          lk_emit = has_owner;
        end
      end else if (mode_q == MODE_CONTENT) begin
        lk_kind = KIND_FORWARD;
        lk_dest = rd_q.requester;
        if (is_wr) begin
          // Stray content with nothing pending is dropped.
          lk_write         = (rd_q.pending != '0);
          lk_entry.pending = pend_dec;
          lk_emit          = (rd_q.pending == PEND_W'(1));
        end else begin
          lk_emit = 1'b1;
        end
      end else if (mode_q == MODE_ACK) begin
        lk_write        = 1'b1;
        lk_entry.owners = ack_owners;
      end else begin
        lk_write = 1'b0;
      end
    end
  end

  // Owner walk.
  logic             scan_last;
  logic [NODES-1:0] rem_next;
  dir_entry_t       scan_entry;

  assign rem_next  = rem_q & (rem_q - NODES'(1));
  assign scan_last = (rem_next == '0) || (cnt_q == PEND_W'(MAX_RESULTS - 1));

  always_comb begin
    scan_entry           = rd_q;
    scan_entry.requester = src_q;
    scan_entry.pending   = cnt_q + PEND_W'(1);
  end

  // Memory write port.
  logic                      mem_we;
  logic [DIR_INDEX_BITS-1:0] wr_addr;
  dir_entry_t                wr_data;
  dir_entry_t                reset_entry;

  always_comb begin
    reset_entry           = '0;
    reset_entry.owners[0] = 1'b1;
  end

  always_comb begin
    mem_we  = 1'b0;
    wr_addr = idx_q;
    wr_data = lk_entry;
    priority if (cmd_i.clr_we) begin
      mem_we  = 1'b1;
      wr_addr = clr_cnt_q;
      wr_data = reset_entry;
    end else if (cmd_i.lk_commit) begin
      mem_we  = lk_write;
    end else if (cmd_i.scan_emit) begin
      mem_we  = scan_last;
      wr_data = scan_entry;
    end else begin
      mem_we  = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      dir_mem[wr_addr] <= wr_data;
    end
    if (cmd_i.load) begin
      rd_q <= dir_mem[in_idx];
    end
  end

  // Clearing sweep counter.
  assign clr_cnt_d = cmd_i.clr_we ? clr_cnt_q + DIR_INDEX_BITS'(1) : clr_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      clr_cnt_q   <= clr_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Item registers and owner walk registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q <= s_tuser_i;
      src_q  <= in_src;
      addr_q <= in_addr;
      perm_q <= in_perm;
      idx_q  <= in_idx;
    end
    if (cmd_i.scan_load) begin
      rem_q <= rd_q.owners;
      cnt_q <= '0;
    end else if (cmd_i.scan_emit) begin
      rem_q <= rem_next;
      cnt_q <= cnt_q + PEND_W'(1);
    end
  end

  // Output register.
  logic emit;
  assign emit = cmd_i.lk_emit || cmd_i.scan_emit;

  always_comb begin
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (m_tready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.lk_emit) begin
      out_kind_q <= lk_kind;
      out_dest_q <= lk_dest;
      out_addr_q <= addr_q;
      out_perm_q <= perm_q;
      out_last_q <= 1'b1;
    end else if (cmd_i.scan_emit) begin
      out_kind_q <= KIND_REQUEST;
      out_dest_q <= NODE_W'(lowest_idx(rem_q));
      out_addr_q <= addr_q;
      out_perm_q <= PERM_WRITE;
      out_last_q <= scan_last;
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = {3'b000, out_perm_q, out_addr_q, out_dest_q};
  assign m_tuser_o  = out_kind_q;
  assign m_tlast_o  = out_last_q;

  assign status_o.clr_last  = (clr_cnt_q == DIR_INDEX_BITS'(DIR_DEPTH - 1));
  assign status_o.is_scan   = is_scan;
  assign status_o.lk_emit   = lk_emit;
  assign status_o.out_free  = !out_valid_q || m_tready_i;
  assign status_o.scan_last = scan_last;

endmodule

// File: rtl/core/page_coherence_directory_core.sv
// ----------------------------------------------------------------------------
// page_coherence_directory_core: directory engine for page coherence
// Input channel: one coherence message per beat (request, content or ack).
// Output channel: the messages the directory sends in reply, the final one
// of each input marked by tlast.
// After reset the directory runs a clearing sweep over all DIR_DEPTH entries
// (1024 with the default sizes) that gives every entry node 0 as sole owner;
// the input is not ready during the sweep.
// Each input beat goes through a capture step and a lookup step in the
// directory memory, whose read port is registered. A message with at most
// one result frees the input when its lookup step ends. A write request
// walks the owner set one owner per cycle while the output register is
// free, serving up to eight owners.
// Results pass through a single output register. The input side may take
// a new beat while a result still waits there. When the receiver stalls,
// the walk and the lookup hold until the register is free again; nothing
// is dropped.
// ----------------------------------------------------------------------------
module page_coherence_directory_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // tdata, lowest bit up: source_node[2:0], msg_addr[34:3], perm[36:35],
  // zero fill [39:37].
  input  logic [pcd_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // tuser: mode[1:0].
  input  logic [pcd_pkg::MODE_W-1:0]       s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // tdata, lowest bit up: dest_node[2:0], out_msg_addr[34:3],
  // out_perm[36:35], zero fill [39:37].
  output logic [pcd_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  // tuser: msg_kind[0].
  output logic [pcd_pkg::KIND_W-1:0]       m_axis_tuser,
  output logic                             m_axis_tlast
);
  import pcd_pkg::*;

  pcd_cmd_t    cmd;
  pcd_status_t status;

  // The sequencer decides each step; the datapath owns all storage.
  pcd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  pcd_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .status_o   (status),
    .s_tdata_i  (s_axis_tdata),
    .s_tuser_i  (s_axis_tuser),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .m_tdata_o  (m_axis_tdata),
    .m_tuser_o  (m_axis_tuser),
    .m_tlast_o  (m_axis_tlast)
  );

  assign s_axis_tready = cmd.ready;

`ifndef SYNTH
  // One item at a time: an accepted beat closes the input for the lookup.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted again during lookup");

  // A result is never loaded over one the receiver has not taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !((cmd.lk_emit || cmd.scan_emit) && m_axis_tvalid && !m_axis_tready))
    else $error("output register overwritten");

  // The input stays closed while the directory is being cleared.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.clr_we |-> !s_axis_tready)
    else $error("input ready during clearing sweep");
`endif

endmodule

// File: tb/pcd_scoreboard_pkg.sv
// ----------------------------------------------------------------------------
// pcd_scoreboard_pkg: reply scoreboard of the page coherence directory
// Keeps a mirror of every directory entry, works out the replies that each
// accepted message causes and matches the replies that come back in order.
// ----------------------------------------------------------------------------
package pcd_scoreboard_pkg;

  import pcd_pkg::*;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [NODE_W-1:0] dest;
    logic [ADDR_W-1:0] addr;
    logic [PERM_W-1:0] perm;
    logic              is_last;
  } dir_reply_t;

  class directory_mirror;

    logic [NODES-1:0]  owner_tbl     [DIR_DEPTH];
    logic [NODE_W-1:0] requester_tbl [DIR_DEPTH];
    logic [PEND_W-1:0] pending_tbl   [DIR_DEPTH];
    dir_reply_t        replies_due   [$];
    int                mismatches;

    function new();
      for (int i = 0; i < DIR_DEPTH; i++) begin
        owner_tbl[i]     = NODES'(1);
        requester_tbl[i] = '0;
        pending_tbl[i]   = '0;
      end
      mismatches = 0;
    endfunction

    function void queue_reply(logic [KIND_W-1:0] kind, int dest, logic [ADDR_W-1:0] addr,
                              logic [PERM_W-1:0] perm, logic is_last);
      dir_reply_t r;
      r.kind    = kind;
      r.dest    = NODE_W'(dest);
      r.addr    = addr;
      r.perm    = perm;
      r.is_last = is_last;
      replies_due.push_back(r);
    endfunction

    // Updates the mirrored entry for one accepted message and queues the
    // replies it causes, the final one flagged.
    function void note_message(logic [MODE_W-1:0] mode, logic [NODE_W-1:0] src,
                               logic [ADDR_W-1:0] addr, logic [PERM_W-1:0] perm);
      logic [DIR_INDEX_BITS-1:0] idx;
      logic [NODES-1:0]          owners;
      int                        total;
      int                        sent;
      logic                      found;
      idx    = addr[PAGE_SHIFT +: DIR_INDEX_BITS];
      owners = owner_tbl[idx];
      total  = 0;
      sent   = 0;
      found  = 1'b0;
      if (perm != PERM_READ && perm != PERM_WRITE) return;
      case (mode)
        MODE_REQUEST: begin
          requester_tbl[idx] = src;
          if (perm == PERM_WRITE) begin
            for (int n = 0; n < NODES; n++) begin
              if (owners[n] && total < MAX_RESULTS) total++;
            end
            for (int n = 0; n < NODES; n++) begin
              if (owners[n] && sent < total) begin
                queue_reply(KIND_REQUEST, n, addr, PERM_WRITE, sent == total - 1);
                sent++;
              end
            end
            pending_tbl[idx] = PEND_W'(total);
          end else begin
            for (int n = 0; n < NODES; n++) begin
              if (owners[n] && !found) begin
                queue_reply(KIND_REQUEST, n, addr, PERM_READ, 1'b1);
                found = 1'b1;
              end
            end
          end
        end
        MODE_CONTENT: begin
          if (perm == PERM_WRITE) begin
            // Content with no invalidation outstanding is dropped.
            if (pending_tbl[idx] != '0) begin
              pending_tbl[idx] = pending_tbl[idx] - PEND_W'(1);
              if (pending_tbl[idx] == '0) begin
                queue_reply(KIND_FORWARD, int'(requester_tbl[idx]), addr, PERM_WRITE, 1'b1);
              end
            end
          end else begin
            queue_reply(KIND_FORWARD, int'(requester_tbl[idx]), addr, PERM_READ, 1'b1);
          end
        end
        MODE_ACK: begin
          if (perm == PERM_WRITE) owners = '0;
          if (int'(src) < NODES) owners[src] = 1'b1;
          owner_tbl[idx] = owners;
        end
        default: begin
        end
      endcase
    endfunction

    function int pending_at(logic [ADDR_W-1:0] addr);
      return int'(pending_tbl[addr[PAGE_SHIFT +: DIR_INDEX_BITS]]);
    endfunction

    function int outstanding();
      return replies_due.size();
    endfunction

    // Compares one reply beat with the oldest reply still due.
    function void match_reply(dir_reply_t got);
      dir_reply_t want;
      if (replies_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected reply: kind=%0d dest=%0d addr=%08h perm=%0d last=%0d",
                   got.kind, got.dest, got.addr, got.perm, got.is_last);
        end
        return;
      end
      want = replies_due.pop_front();
      if (got.kind != want.kind || got.dest != want.dest || got.addr != want.addr ||
          got.perm != want.perm || got.is_last != want.is_last) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("reply mismatch: expected kind=%0d dest=%0d addr=%08h perm=%0d last=%0d",
                   want.kind, want.dest, want.addr, want.perm, want.is_last);
          $display("                actual   kind=%0d dest=%0d addr=%08h perm=%0d last=%0d",
                   got.kind, got.dest, got.addr, got.perm, got.is_last);
        end
      end
    endfunction

  endclass

endpackage

// File: tb/tb_page_coherence_directory_core.sv
// ----------------------------------------------------------------------------
// tb_page_coherence_directory_core: self-checking bench of the directory core
// Drives coherence messages into the input stream, mirrors the directory in
// a scoreboard and checks every reply beat in order. A directed opening
// covers the corner cases, then random transactions on a few hot pages run
// with random idling on both sides, a long receiver stall and a full drain.
// ----------------------------------------------------------------------------
module tb_page_coherence_directory_core;

  import pcd_pkg::*;
  import pcd_scoreboard_pkg::*;

  // The cycle limit covers the clearing sweep and then, for each message,
  // its work, up to eight replies, a receiver stall per reply and a gap on
  // the input. All messages of the run plus the long stalls stay far below
  // this bound.
  localparam int CYCLE_LIMIT   = 200000;
  localparam int RANDOM_BEATS  = 140;
  localparam int QUIET_FROM    = 115;
  localparam int LONG_HOLD     = 300;
  localparam int DRAIN_CYCLES  = 20;

  // Codes the block does not act on.
  localparam logic [MODE_W-1:0] MODE_UNUSED   = 2'd3;
  localparam logic [PERM_W-1:0] PERM_NONE     = 2'd0;
  localparam logic [PERM_W-1:0] PERM_RESERVED = 2'd3;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic [MODE_W-1:0]      s_axis_tuser  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [KIND_W-1:0]      m_axis_tuser;
  logic                   m_axis_tlast;

  directory_mirror mirror;

  // Shared knobs between the sender and the receiver.
  bit quiet;           // set for the final stretch: no idling on either side
  bit hold_request;    // asks the receiver for one long stall
  int counted_beats;   // accepted beats that the block acts on
  int cycle_cnt;

  logic [DIR_INDEX_BITS-1:0] page_slots [4];

  page_coherence_directory_core u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // A random address on one of the hot pages: the directory index bits are
  // fixed by the slot, every other bit is random.
  function automatic logic [ADDR_W-1:0] hot_addr(int slot);
    logic [ADDR_W-1:0] a;
    a = $urandom;
    a[PAGE_SHIFT +: DIR_INDEX_BITS] = page_slots[slot];
    return a;
  endfunction

  // Offers one message beat and returns at the edge where it is taken. The
  // valid stays high afterwards so that back-to-back beats need no gap.
  task automatic offer_beat(logic [MODE_W-1:0] mode, logic [NODE_W-1:0] src,
                            logic [ADDR_W-1:0] addr, logic [PERM_W-1:0] perm);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= {3'b000, perm, addr, src};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    mirror.note_message(mode, src, addr, perm);
    if (mode != MODE_UNUSED && (perm == PERM_READ || perm == PERM_WRITE)) counted_beats++;
  endtask

  // Stops offering until every reply already due has come back. At least
  // one edge passes so the valid is never dropped and raised in one step.
  task automatic wait_replies_done();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (mirror.outstanding() != 0);
  endtask

  // A complete write transaction: the request, one content beat per
  // invalidation sent, then the write ack from the new owner. Now and then
  // the content count is off by one so stray and missing content occur.
  task automatic write_transaction(int slot);
    logic [NODE_W-1:0] req_node;
    int                replies;
    req_node = NODE_W'($urandom_range(0, NODES - 1));
    offer_beat(MODE_REQUEST, req_node, hot_addr(slot), PERM_WRITE);
    replies = mirror.pending_at({10'd0, page_slots[slot], 12'd0});
    case ($urandom_range(0, 7))
      0: replies = replies + 1;
      1: replies = (replies > 0) ? replies - 1 : 0;
      default: begin
      end
    endcase
    repeat (replies) begin
      offer_beat(MODE_CONTENT, NODE_W'($urandom_range(0, NODES - 1)),
                 hot_addr(slot), PERM_WRITE);
    end
    offer_beat(MODE_ACK, ($urandom_range(0, 5) == 0) ? NODE_W'($urandom) : req_node,
               hot_addr(slot), PERM_WRITE);
  endtask

  // A read transaction: request, the content coming back, the read ack
  // that adds the reader to the owner set.
  task automatic read_transaction(int slot);
    logic [NODE_W-1:0] req_node;
    req_node = NODE_W'($urandom_range(0, NODES - 1));
    offer_beat(MODE_REQUEST, req_node, hot_addr(slot), PERM_READ);
    offer_beat(MODE_CONTENT, NODE_W'($urandom), hot_addr(slot), PERM_READ);
    offer_beat(MODE_ACK, req_node, hot_addr(slot), PERM_READ);
  endtask

  // Receiver: checks each reply beat, then picks the next ready value.
  // Idle bursts and the long hold are counted here, in cycles.
  initial begin : reply_sink
    int         idle_left;
    dir_reply_t got;
    idle_left = 0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        got.kind    = m_axis_tuser;
        got.dest    = m_axis_tdata[2:0];
        got.addr    = m_axis_tdata[34:3];
        got.perm    = m_axis_tdata[36:35];
        got.is_last = m_axis_tlast;
        mirror.match_reply(got);
      end
      if (idle_left > 0) begin
        idle_left--;
        m_axis_tready <= 1'b0;
      end else if (hold_request) begin
        // One long stall so the output register and then the input fill up.
        hold_request = 1'b0;
        idle_left = LONG_HOLD - 1;
        m_axis_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        idle_left = $urandom_range(1, 13) - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Watchdog: a hung handshake ends the run here.
  initial begin : watchdog
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("FAILURE");
    $finish;
  end

  initial begin : stimulus
    int   pick;
    int   slot;
    bit   held;
    bit   drained;
    mirror       = new();
    quiet        = 1'b0;
    hold_request = 1'b0;
    held         = 1'b0;
    drained      = 1'b0;

    page_slots[0] = '0;
    page_slots[1] = '1;
    page_slots[2] = DIR_INDEX_BITS'($urandom);
    page_slots[3] = DIR_INDEX_BITS'($urandom);

    // Reset is asserted once, at the start. The input stays not ready for
    // the clearing sweep, which the first handshake simply waits out.
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part. Read flow on the all-zero page: the request goes to
    // node 0, the content is forwarded to the reader, acks add owners.
    offer_beat(MODE_REQUEST, 3'd3, 32'h0000_0000, PERM_READ);
    offer_beat(MODE_CONTENT, 3'd0, 32'h0000_0000, PERM_READ);
    offer_beat(MODE_ACK,     3'd3, 32'h0000_0000, PERM_READ);
    offer_beat(MODE_ACK,     3'd7, 32'h0000_0000, PERM_READ);

    // All-ones page: every node becomes an owner, so the write request
    // fans out to the maximum of eight invalidations.
    for (int n = 1; n < NODES; n++) begin
      offer_beat(MODE_ACK, NODE_W'(n), 32'hFFFF_FFFF, PERM_READ);
    end
    offer_beat(MODE_REQUEST, 3'd5, 32'hFFFF_FFFF, PERM_WRITE);
    for (int n = 0; n < NODES; n++) begin
      offer_beat(MODE_CONTENT, NODE_W'(n), 32'hFFFF_FFFF, PERM_WRITE);
    end
    // Stray write content with nothing pending must be dropped quietly.
    offer_beat(MODE_CONTENT, 3'd2, 32'hFFFF_FFFF, PERM_WRITE);
    // The write ack leaves the writer as the sole owner.
    offer_beat(MODE_ACK, 3'd5, 32'hFFFF_FFFF, PERM_WRITE);

    // Messages the block ignores: unknown mode and both unknown perms.
    offer_beat(MODE_UNUSED,  3'd1, 32'h0000_0000, PERM_READ);
    offer_beat(MODE_REQUEST, 3'd6, 32'hFFFF_FFFF, PERM_NONE);
    offer_beat(MODE_ACK,     3'd4, 32'h0000_0000, PERM_RESERVED);

    wait_replies_done();

    // Random part: mostly full transactions on the hot pages, some extra
    // read acks to grow owner sets, and a share of noise.
    counted_beats = 0;
    while (counted_beats < RANDOM_BEATS) begin
      if (counted_beats >= QUIET_FROM) quiet = 1'b1;
      if (!held && counted_beats >= 60) begin
        held = 1'b1;
        hold_request = 1'b1;
      end
      if (!drained && counted_beats >= 100) begin
        drained = 1'b1;
        wait_replies_done();
      end
      slot = $urandom_range(0, 3);
      pick = $urandom_range(0, 9);
      case (pick)
        0, 1, 2, 3: write_transaction(slot);
        4, 5, 6:    read_transaction(slot);
        7: begin
          repeat ($urandom_range(1, 3)) begin
            offer_beat(MODE_ACK, NODE_W'($urandom), hot_addr(slot), PERM_READ);
          end
        end
        8: begin
          offer_beat(MODE_W'($urandom), NODE_W'($urandom),
                     ($urandom_range(0, 1) == 0) ? ADDR_W'($urandom) : hot_addr(slot),
                     PERM_W'($urandom));
        end
        default: begin
          // Broken sequences: content with no request before it.
          offer_beat(MODE_CONTENT, NODE_W'($urandom), hot_addr(slot),
                     ($urandom_range(0, 1) == 0) ? PERM_WRITE : PERM_READ);
        end
      endcase
    end

    // Drain: everything due must arrive, then the bench waits on in case a
    // reply shows up that nothing asked for.
    wait_replies_done();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mirror.mismatches == 0 && mirror.outstanding() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/pcd_pkg.sv
rtl/core/pcd_ctrl.sv
rtl/core/pcd_datapath.sv
rtl/core/page_coherence_directory_core.sv
tb/pcd_scoreboard_pkg.sv
tb/tb_page_coherence_directory_core.sv
